@@ src/ttip_pkg.sv @@
// Shared types and constants for the text to int64 parser.
package ttip_pkg;

    localparam int unsigned MAX_LENGTH = 65535;
    localparam int unsigned CNT_W      = $clog2(64'(MAX_LENGTH) + 64'd1);

    localparam int unsigned BASE_W = 6;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned VAL_W  = 64;
    localparam int unsigned USED_W = 16;

    localparam logic REG_NUMBER_BASE = 1'b0;
    localparam logic REG_SIGNED_MODE = 1'b1;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_SIGN   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_PREFIX = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5,
        PH_FAIL   = 3'd6
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [VAL_W-1:0]    magnitude;
        logic                negative;
        logic                overflowed;
        logic [BASE_W-1:0]   base;
        logic [CNT_W-1:0]    char_count;
        logic [CNT_W-1:0]    used_count;
        logic                failed;
    } parse_state_t;

    typedef struct packed {
        logic                parse_ok;
        logic [USED_W-1:0]   chars_used;
        logic [VAL_W-1:0]    value_bits;
    } result_t;

    localparam parse_state_t PARSE_RESET = '{
        phase:      PH_SPACE,
        magnitude:  '0,
        negative:   1'b0,
        overflowed: 1'b0,
        base:       '0,
        char_count: '0,
        used_count: '0,
        failed:     1'b0
    };

endpackage

@@ src/ttip_step.sv @@
// Next-state and result logic for one word of the parser.
module ttip_step
    import ttip_pkg::*;
(
    input  parse_state_t        state,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic                end_of_text,
    input  logic [BASE_W-1:0]   number_base,
    input  logic                signed_mode,
    output parse_state_t        state_next,
    output result_t             result
);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_A_TEN  = 8'h57;
    localparam logic [7:0] CASE_BIT  = 8'h20;
    localparam logic [VAL_W-1:0] NEG_LIMIT = {1'b1, {(VAL_W-1){1'b0}}};
    localparam int unsigned PROD_W = VAL_W + BASE_W + 1;

    typedef struct packed {
        logic              valid;
        logic [BASE_W-1:0] value;
    } digit_t;

    function automatic digit_t digit_of(input logic [7:0] c, input logic [BASE_W-1:0] b);
        digit_t     d;
        logic [7:0] lc;
        logic [7:0] off;
        d.valid = 1'b0;
        d.value = '0;
        lc  = c | CASE_BIT;
        off = lc - CH_LOW_A;
        if (b >= 6'd2 && b <= 6'd36 && c >= CH_ZERO)
        begin
            if (c <= CH_NINE)
            begin
                d.value = BASE_W'(c - CH_ZERO);
                d.valid = (c - CH_ZERO) < 8'(b);
            end
            else if (b > 6'd10 && lc >= CH_LOW_A && off < 8'(b - 6'd10))
            begin
                d.valid = 1'b1;
                d.value = BASE_W'(lc - CH_A_TEN);
            end
        end
        return d;
    endfunction

    logic [BASE_W-1:0] base_in;
    logic [BASE_W-1:0] fc_base;
    logic [BASE_W-1:0] az_base;
    logic [BASE_W-1:0] eff_base;
    digit_t            dig;
    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0]  cnt_next;
    logic [7:0]        lc;
    logic              is_space;
    logic              bad_base;

    assign base_in  = (state.phase == PH_SPACE) ? number_base : state.base;
    assign fc_base  = (base_in == '0) ? 6'd10 : base_in;
    assign az_base  = (state.base == '0) ? 6'd8 : state.base;
    assign eff_base = (state.phase == PH_ZERO) ? az_base :
                      (state.phase == PH_SPACE || state.phase == PH_SIGN) ? fc_base :
                      state.base;
    assign dig      = digit_of(char_code, eff_base);
    // single shared multiply-add; carry-out beyond 64 bits flags overflow
    assign prod     = PROD_W'(state.magnitude) * PROD_W'(eff_base) + PROD_W'(dig.value);
    assign cnt_next = (state.char_count < CNT_W'(MAX_LENGTH)) ? state.char_count + 1'b1
                                                               : state.char_count;
    assign lc       = char_code | CASE_BIT;
    assign is_space = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
    assign bad_base = (number_base == 6'd1) || (number_base > 6'd36);

    always_comb
    begin
        logic take_now;
        logic fail_now;
        logic first_now;
        take_now   = 1'b0;
        fail_now   = 1'b0;
        first_now  = 1'b0;
        state_next = state;
        result     = '0;
        if (!end_of_text)
        begin
            state_next.char_count = cnt_next;
            unique case (state.phase)
                PH_SPACE:
                begin
                    if (!is_space)
                    begin
                        state_next.base = number_base;
                        if (bad_base)
                            fail_now = 1'b1;
                        else if (char_code == CH_MINUS)
                        begin
                            if (signed_mode)
                            begin
                                state_next.negative = 1'b1;
                                state_next.phase    = PH_SIGN;
                            end
                            else
                                fail_now = 1'b1;
                        end
                        else if (char_code == CH_PLUS)
                            state_next.phase = PH_SIGN;
                        else
                            first_now = 1'b1;
                    end
                end
                PH_SIGN:   first_now = 1'b1;
                PH_ZERO:
                begin
                    if (lc == CH_LOW_X && (state.base == '0 || state.base == 6'd16))
                    begin
                        state_next.base  = 6'd16;
                        state_next.phase = PH_PREFIX;
                    end
                    else if (lc == CH_LOW_B && (state.base == '0 || state.base == 6'd2))
                    begin
                        state_next.base  = 6'd2;
                        state_next.phase = PH_PREFIX;
                    end
                    else
                        take_now = 1'b1;
                end
                PH_PREFIX:
                begin
                    if (dig.valid)
                        take_now = 1'b1;
                    else
                        fail_now = 1'b1;
                end
                PH_DIGITS: take_now = 1'b1;
                default: ;
            endcase

            if (first_now)
            begin
                if (char_code == CH_ZERO)
                begin
                    state_next.magnitude  = '0;
                    state_next.used_count = cnt_next;
                    state_next.phase      = PH_ZERO;
                end
                else if (dig.valid)
                    take_now = 1'b1;
                else
                    fail_now = 1'b1;
            end

            if (take_now)
            begin
                if (dig.valid)
                begin
                    state_next.magnitude  = prod[VAL_W-1:0];
                    state_next.overflowed = state.overflowed | (|prod[PROD_W-1:VAL_W]);
                    state_next.used_count = cnt_next;
                    state_next.base       = eff_base;
                    state_next.phase      = PH_DIGITS;
                end
                else
                    state_next.phase = PH_DONE;
            end

            if (fail_now)
            begin
                state_next.failed = 1'b1;
                state_next.phase  = PH_FAIL;
            end
        end
        else
        begin
            if (!state.failed && !state.overflowed &&
                (state.phase == PH_ZERO || state.phase == PH_DIGITS ||
                 state.phase == PH_DONE))
            begin
                if (signed_mode)
                begin
                    if (state.negative)
                        result.parse_ok = (state.magnitude <= NEG_LIMIT);
                    else
                        result.parse_ok = !state.magnitude[VAL_W-1];
                end
                else
                    result.parse_ok = !state.negative;
            end
            if (result.parse_ok)
            begin
                result.value_bits = state.negative ? -state.magnitude : state.magnitude;
                result.chars_used = USED_W'(state.used_count);
            end
            state_next = PARSE_RESET;
        end
    end

endmodule

@@ src/text_to_int64_parser.sv @@
// Top level of the streaming text to int64 parser.
// Takes one character word per cycle on the slave stream; a word with tlast
// high ends the string and produces one result word, registered on the master
// stream once that word leaves the input register. Sustained rate is one word per
// cycle, paced by the single magnitude-times-base multiply-add with overflow
// check between the input register and the parse state. A tlast word waits in
// the input register while an earlier result is still unaccepted, which stalls
// the slave stream. Words with tlast low produce no result.
module text_to_int64_parser
    import ttip_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] char_code
    input  logic                s_tlast,    // end_of_text

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [87:0]         m_tdata,    // [63:0] value_bits, [79:64] chars_used,
                                            // [80] parse_ok, rest zero

    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [BASE_W-1:0]   cfg_data
);

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    logic [BASE_W-1:0] number_base_reg;
    logic              signed_mode_reg;
    parse_state_t      state_reg;
    parse_state_t      state_next;
    result_t           result;
    logic              out_valid_reg;
    result_t           out_data_reg;
    logic              advance;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_data_reg};

    ttip_step u_step (
        .state       (state_reg),
        .char_code   (in_char_reg),
        .end_of_text (in_last_reg),
        .number_base (number_base_reg),
        .signed_mode (signed_mode_reg),
        .state_next  (state_next),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= 6'd10;
            signed_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUMBER_BASE: number_base_reg <= cfg_data;
                REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= PARSE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                state_reg <= state_next;
            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
            out_data_reg <= result;
    end

endmodule
